FILE: hw/rtl/plti_pkg.sv
// shared types, constants and codes for the piecewise-linear table interpolator
`default_nettype none

package plti_pkg;

  // default table depth
  localparam int PLTI_MAX_ENTRIES = 16;

  // field widths
  localparam int BP_W    = 16;
  localparam int VAL_W   = 16;
  localparam int CFG_W   = 5;
  localparam int IDX_W   = 4;
  localparam int FLAG_W  = 2;
  localparam int PROD_W  = 2 * VAL_W;

  // value lanes carried per table row
  localparam int NUM_VALS   = 2;
  localparam int VAL_RADIUS = 0;
  localparam int VAL_PASS   = 1;

  // item mode codes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // range flag codes
  localparam logic [FLAG_W-1:0] FLAG_INSIDE = 2'd0;
  localparam logic [FLAG_W-1:0] FLAG_FIRST  = 2'd1;
  localparam logic [FLAG_W-1:0] FLAG_BEYOND = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } plti_state_e;

  // one table row
  typedef struct packed {
    logic [BP_W-1:0]                bp;
    logic [NUM_VALS-1:0][VAL_W-1:0] val;
  } plti_row_t;

  // controller to datapath
  typedef struct packed {
    logic              tbl_write;
    logic              q_load;
    logic              idx_clr;
    logic              idx_inc;
    logic              prev_save;
    logic              ops_load;
    logic              div_start;
    logic              kind_load;
    logic [FLAG_W-1:0] kind;
    logic              out_load;
  } plti_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic first;
    logic last;
    logic div_busy;
  } plti_sts_t;

endpackage

`default_nettype wire

FILE: hw/rtl/plti_div.sv
// bit-serial restoring divider, one quotient bit per cycle
`default_nettype none

module plti_div import plti_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [PROD_W-1:0] num_i,
  input  wire logic [VAL_W-1:0]  den_i,
  output logic      [VAL_W-1:0]  quo_o,
  output logic                   busy_o
);

  localparam int CntW = $clog2(VAL_W + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [VAL_W-1:0] rem_q, rem_d;
  logic [VAL_W-1:0] quo_q, quo_d;
  logic [VAL_W-1:0] den_q, den_d;
  logic [VAL_W:0]   trial;
  logic [VAL_W:0]   diff;
  logic             ge;

  // one restoring step; the caller guarantees the quotient fits VAL_W bits,
  // so the upper half of the numerator starts below the divisor
  always_comb begin
    trial = {rem_q, quo_q[VAL_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = (trial >= {1'b0, den_q});
    cnt_d = cnt_q;
    rem_d = rem_q;
    quo_d = quo_q;
    den_d = den_q;
    if (start_i) begin
      rem_d = num_i[PROD_W-1:VAL_W];
      quo_d = num_i[VAL_W-1:0];
      den_d = den_i;
      cnt_d = CntW'(VAL_W);
    end else if (cnt_q != '0) begin
      rem_d = ge ? diff[VAL_W-1:0] : trial[VAL_W-1:0];
      quo_d = {quo_q[VAL_W-2:0], ge};
      cnt_d = cnt_q - 1'b1;
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign busy_o = (cnt_q != '0);

endmodule

`default_nettype wire

FILE: hw/rtl/plti_dp.sv
// datapath: row tables, search compare, lane multipliers and dividers, result registers
`default_nettype none

module plti_dp import plti_pkg::*; #(
  parameter int MaxEntries = PLTI_MAX_ENTRIES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire plti_cmd_t        cmd_i,
  output plti_sts_t             sts_o,
  input  wire logic             cfg_valid_i,
  input  wire logic [CFG_W-1:0] entries_in_use_i,
  input  wire logic [IDX_W-1:0] entry_index_i,
  input  wire logic [BP_W-1:0]  breakpoint_value_i,
  input  wire logic [VAL_W-1:0] radius_value_i,
  input  wire logic [VAL_W-1:0] pass_length_value_i,
  input  wire logic [BP_W-1:0]  query_value_i,
  output logic      [VAL_W-1:0] radius_out_o,
  output logic      [VAL_W-1:0] pass_length_out_o,
  output logic     [FLAG_W-1:0] range_flag_o
);

  localparam int AW = $clog2(MaxEntries);

  // table memory and its registered read port
  plti_row_t mem [MaxEntries];
  plti_row_t rd_q;
  plti_row_t prev_q;
  plti_row_t wr_row;
  logic      wr_ok;

  logic [CFG_W-1:0] entries_in_use_q;
  logic [AW-1:0]    idx_q, idx_d;
  logic [AW-1:0]    last_idx;
  int               n_use;

  logic [BP_W-1:0]   q_q;
  logic [FLAG_W-1:0] kind_q;
  logic [BP_W:0]     dq_full;
  logic [BP_W:0]     den_full;
  logic [VAL_W-1:0]  dq_q;
  logic [VAL_W-1:0]  den_q;

  logic [NUM_VALS-1:0][VAL_W:0]   vdiff;
  logic [NUM_VALS-1:0][VAL_W-1:0] mag_q;
  logic [NUM_VALS-1:0]            neg_q;
  logic [NUM_VALS-1:0][VAL_W-1:0] lo_q;
  logic [NUM_VALS-1:0][VAL_W-1:0] quo;
  logic [NUM_VALS-1:0][VAL_W-1:0] res;
  logic [NUM_VALS-1:0]            busy;
  logic [NUM_VALS-1:0][PROD_W-1:0] prod;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_in_use_q <= CFG_W'(1);
    end else if (cfg_valid_i) begin
      entries_in_use_q <= entries_in_use_i;
    end
  end

  // rows in use, clamped to between 1 and the table depth
  always_comb begin
    n_use = int'(entries_in_use_q);
    if (n_use < 1) begin
      n_use = 1;
    end
    if (n_use > MaxEntries) begin
      n_use = MaxEntries;
    end
    last_idx = AW'(n_use - 1);
  end

  // row index; the memory reads at the next index so rd_q tracks idx_q
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.idx_clr) begin
      idx_d = '0;
    end else if (cmd_i.idx_inc) begin
      idx_d = idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else begin
      idx_q <= idx_d;
    end
  end

  // row write, out-of-range indexes dropped
  assign wr_ok  = (int'(entry_index_i) < MaxEntries);
  always_comb begin
    wr_row.bp              = breakpoint_value_i;
    wr_row.val[VAL_RADIUS] = radius_value_i;
    wr_row.val[VAL_PASS]   = pass_length_value_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tbl_write && wr_ok) begin
      mem[AW'(entry_index_i)] <= wr_row;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem[idx_d];
  end

  // query, previous row and result kind
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_load) begin
      q_q <= query_value_i;
    end
    if (cmd_i.prev_save) begin
      prev_q <= rd_q;
    end
    if (cmd_i.kind_load) begin
      kind_q <= cmd_i.kind;
    end
  end

  // search status
  assign sts_o.hit      = ($signed(rd_q.bp) >= $signed(q_q));
  assign sts_o.first    = (idx_q == '0);
  assign sts_o.last     = (idx_q == last_idx);
  assign sts_o.div_busy = |busy;

  // segment operands; prev bp < q <= cur bp, so both differences lie in 1..65535
  // and the interpolated value never leaves the range of its two end values
  assign dq_full  = {q_q[BP_W-1], q_q} - {prev_q.bp[BP_W-1], prev_q.bp};
  assign den_full = {rd_q.bp[BP_W-1], rd_q.bp} - {prev_q.bp[BP_W-1], prev_q.bp};

  always_ff @(posedge clk_i) begin
    if (cmd_i.ops_load) begin
      dq_q  <= dq_full[VAL_W-1:0];
      den_q <= den_full[VAL_W-1:0];
    end
  end

  // per-value lanes: difference, product into the divider, final add or subtract
  for (genvar l = 0; l < NUM_VALS; l++) begin : g_lane
    assign vdiff[l] = {1'b0, rd_q.val[l]} - {1'b0, prev_q.val[l]};

    always_ff @(posedge clk_i) begin
      if (cmd_i.ops_load) begin
        neg_q[l] <= vdiff[l][VAL_W];
        mag_q[l] <= vdiff[l][VAL_W] ? (~vdiff[l][VAL_W-1:0] + 1'b1) : vdiff[l][VAL_W-1:0];
        lo_q[l]  <= prev_q.val[l];
      end
    end

    assign prod[l] = dq_q * mag_q[l];

    plti_div u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .start_i (cmd_i.div_start),
      .num_i   (prod[l]),
      .den_i   (den_q),
      .quo_o   (quo[l]),
      .busy_o  (busy[l])
    );

    assign res[l] = neg_q[l] ? (lo_q[l] - quo[l]) : (lo_q[l] + quo[l]);
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      range_flag_o <= kind_q;
      if (kind_q == FLAG_INSIDE) begin
        radius_out_o      <= res[VAL_RADIUS];
        pass_length_out_o <= res[VAL_PASS];
      end else begin
        radius_out_o      <= rd_q.val[VAL_RADIUS];
        pass_length_out_o <= rd_q.val[VAL_PASS];
      end
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/plti_ctrl.sv
// controller: sequences load, search, multiply, divide and result handoff
`default_nettype none

module plti_ctrl import plti_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire logic      mode_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output plti_cmd_t      cmd_o,
  input  wire plti_sts_t sts_i
);

  plti_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (mode_i == MODE_LOAD) begin
            cmd_o.tbl_write = 1'b1;
          end else begin
            cmd_o.q_load  = 1'b1;
            cmd_o.idx_clr = 1'b1;
            state_d       = ST_SEARCH;
          end
        end
      end
      ST_SEARCH: begin
        if (sts_i.hit) begin
          cmd_o.kind_load = 1'b1;
          if (sts_i.first) begin
            cmd_o.kind = FLAG_FIRST;
            state_d    = ST_DONE;
          end else begin
            cmd_o.kind     = FLAG_INSIDE;
            cmd_o.ops_load = 1'b1;
            state_d        = ST_MUL;
          end
        end else if (sts_i.last) begin
          cmd_o.kind_load = 1'b1;
          cmd_o.kind      = FLAG_BEYOND;
          state_d         = ST_DONE;
        end else begin
          cmd_o.prev_save = 1'b1;
          cmd_o.idx_inc   = 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.div_start = 1'b1;
        state_d         = ST_DIV;
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

FILE: hw/rtl/piecewise_linear_table_interp.sv
// top level of the piecewise-linear table interpolator
`default_nettype none

// Table of ascending breakpoints, each with a radius and a pass-length value.
// A load item (mode 0) writes one row and gives no result. A query item
// (mode 1) walks the rows in use one per cycle from row 0 until it finds a
// breakpoint not below the query; a query at or below row 0 returns row 0 with
// flag 1, one beyond the last row in use returns that row with flag 2, and all
// others are interpolated as lo + (q - bp_lo) * (hi - lo) / (bp_hi - bp_lo),
// truncated toward zero, with flag 0. An interpolation then passes through the
// multiply step and the bit-serial divider before its result is registered.
// One query is in flight at a time; a finished result sits in the output
// register while the next item is taken. Rows are undefined until loaded.
// entries_in_use resets to 1; write it only while the block is idle.

module piecewise_linear_table_interp import plti_pkg::*; #(
  parameter int MaxEntries = PLTI_MAX_ENTRIES
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  // item input
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic             mode_i,
  input  wire logic [IDX_W-1:0] entry_index_i,
  input  wire logic [BP_W-1:0]  breakpoint_value_i,
  input  wire logic [VAL_W-1:0] radius_value_i,
  input  wire logic [VAL_W-1:0] pass_length_value_i,
  input  wire logic [BP_W-1:0]  query_value_i,
  // result output
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic      [VAL_W-1:0] radius_out_o,
  output logic      [VAL_W-1:0] pass_length_out_o,
  output logic     [FLAG_W-1:0] range_flag_o,
  // configuration write
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] entries_in_use_i
);

  plti_cmd_t cmd;
  plti_sts_t sts;

  // register writes always taken
  assign cfg_ready_o = 1'b1;

  // control sequencer
  plti_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .mode_i      (mode_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // tables and arithmetic
  plti_dp #(
    .MaxEntries (MaxEntries)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .cfg_valid_i         (cfg_valid_i),
    .entries_in_use_i    (entries_in_use_i),
    .entry_index_i       (entry_index_i),
    .breakpoint_value_i  (breakpoint_value_i),
    .radius_value_i      (radius_value_i),
    .pass_length_value_i (pass_length_value_i),
    .query_value_i       (query_value_i),
    .radius_out_o        (radius_out_o),
    .pass_length_out_o   (pass_length_out_o),
    .range_flag_o        (range_flag_o)
  );

endmodule

`default_nettype wire
